>>> sv/bounded_matrix_from_margins_top_macros.svh
// Assertion macros shared by the bounded matrix block.
`ifndef BOUNDED_MATRIX_FROM_MARGINS_TOP_MACROS_SVH
`define BOUNDED_MATRIX_FROM_MARGINS_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BMM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define BMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/bmm_pkg.sv
// Package: constants and controller/datapath interface types of the matrix builder.
package bmm_pkg;

    localparam int MAX_N_DEF  = 8;
    localparam int TOTAL_W    = 12;
    localparam int CAP_W      = 8;
    localparam int CNT_W      = 4;
    localparam int IDX_W      = 3;
    localparam int MARGIN_W   = 16;
    localparam int MAT_ADDR_W = 2 * IDX_W;
    localparam int MAT_DEPTH  = 1 << MAT_ADDR_W;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_FLD_W  = 1 + IDX_W + IDX_W + CAP_W;

    typedef struct packed {
        logic load;
        logic pick;
        logic fill;
        logic write;
        logic emit_clear;
        logic emit_read;
        logic emit_next;
        logic out_ok;
        logic out_fail;
        logic clear_run;
    } bmm_cmd_t;

    typedef struct packed {
        logic load_end;
        logic margin_zero;
        logic rows_all;
        logic units_zero;
        logic fill_ok;
        logic wcol_last;
        logic emit_last;
    } bmm_stat_t;

endpackage

>>> sv/bounded_matrix_from_margins_top.sv
// Top level of the bounded matrix builder: ports, controller and datapath.
// Takes one (row total, column total) word per cycle while loading; the run ends on
// tlast or at the MAX_N-th word. The build then checks that the row and column totals
// have equal sums and, for every row, selects it, places each unit of that row's total
// in turn (each unit is placed by a single compare chain over the columns), closes the
// row's fill and stores the row's MAX_N entries; an infeasible run stops early. Each
// result entry then passes a store read, an output load and a handoff that waits for
// the sink to be ready. No new pair is taken until the last result of a run is
// accepted.
module bounded_matrix_from_margins_top #(
    parameter int MAX_N = bmm_pkg::MAX_N_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmm_pkg::CAP_W-1:0]      cfg_wdata,   // entry_cap
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bmm_pkg::IN_DATA_W-1:0]  s_axis_tdata, // row_total, column_total
    input  logic                           s_axis_tlast, // last_pair
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // feasible, row_index, column_index, amount, zero pad
    output logic [bmm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast  // last_result
);

    bmm_pkg::bmm_cmd_t  cmd;
    bmm_pkg::bmm_stat_t stat;

    bmm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_axis_tvalid),
        .in_tready  (s_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    bmm_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_tdata  (s_axis_tdata),
        .in_tlast  (s_axis_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_tdata (m_axis_tdata),
        .out_tlast (m_axis_tlast)
    );

endmodule

>>> sv/bmm_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/bmm_dp.sv
// Datapath: margin storage, row and column selection, fill counters, entry store.
`include "bounded_matrix_from_margins_top_macros.svh"
module bmm_dp #(
    parameter int MAX_N = bmm_pkg::MAX_N_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bmm_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic [bmm_pkg::IN_DATA_W-1:0]    in_tdata,
    input  logic                             in_tlast,
    input  bmm_pkg::bmm_cmd_t                cmd,
    output bmm_pkg::bmm_stat_t               stat,
    output logic [bmm_pkg::OUT_DATA_W-1:0]   out_tdata,
    output logic                             out_tlast
);

    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int TW = bmm_pkg::TOTAL_W;
    localparam int CW = bmm_pkg::CNT_W;

    logic [bmm_pkg::CAP_W-1:0]    entry_cap_reg;
    logic [TW-1:0]                row_need_reg [MAX_N];
    logic [TW-1:0]                col_left_reg [MAX_N];
    logic [bmm_pkg::CAP_W-1:0]    row_use_reg  [MAX_N];
    logic [MAX_N-1:0]             served_reg;
    logic [CW-1:0]                pair_cnt_reg;
    logic [CW-1:0]                row_cnt_reg;
    logic [bmm_pkg::MARGIN_W-1:0] margin_reg;
    logic [IW-1:0]                cur_row_reg;
    logic [TW-1:0]                units_reg;
    logic [IW-1:0]                wcol_reg;
    logic [IW-1:0]                er_reg;
    logic [IW-1:0]                ec_reg;
    logic [bmm_pkg::OUT_FLD_W-1:0] out_fld_reg;
    logic                         out_last_reg;

    logic [TW-1:0]                rt;
    logic [TW-1:0]                ct;
    logic [bmm_pkg::CAP_W-1:0]    cap;
    logic [IW-1:0]                pick_row;
    logic [TW-1:0]                best_need;
    logic                         have_row;
    logic [IW-1:0]                pick_col;
    logic [TW-1:0]                best_left;
    logic                         have_col;
    logic                         ram_we;
    logic [bmm_pkg::MAT_ADDR_W-1:0] ram_waddr;
    logic [bmm_pkg::MAT_ADDR_W-1:0] ram_raddr;
    logic [bmm_pkg::CAP_W-1:0]    ram_rdata;
    logic                         ec_wrap;

    assign rt  = in_tdata[TW-1:0];
    assign ct  = in_tdata[2*TW-1:TW];
    assign cap = (entry_cap_reg == '0) ? bmm_pkg::CAP_W'(1) : entry_cap_reg;

    // Pick the unserved row with the largest need, ties to the higher index
    always_comb
    begin
        pick_row  = '0;
        best_need = '0;
        have_row  = 1'b0;
        for (int i = 0; i < MAX_N; i++)
        begin
            if (CW'(i) < pair_cnt_reg && !served_reg[i] &&
                (!have_row || row_need_reg[i] >= best_need))
            begin
                pick_row  = IW'(i);
                best_need = row_need_reg[i];
                have_row  = 1'b1;
            end
        end
    end

    // Pick the uncapped column with the most left, ties to the higher index
    always_comb
    begin
        pick_col  = '0;
        best_left = '0;
        have_col  = 1'b0;
        for (int i = 0; i < MAX_N; i++)
        begin
            if (CW'(i) < pair_cnt_reg && row_use_reg[i] < cap &&
                (!have_col || col_left_reg[i] >= best_left))
            begin
                pick_col  = IW'(i);
                best_left = col_left_reg[i];
                have_col  = 1'b1;
            end
        end
    end

    assign ec_wrap = (CW'(ec_reg) + CW'(1)) == pair_cnt_reg;

    // Status back to the controller
    always_comb
    begin
        stat.load_end    = in_tlast || ((pair_cnt_reg + CW'(1)) == CW'(MAX_N));
        stat.margin_zero = (margin_reg == '0);
        stat.rows_all    = (row_cnt_reg == pair_cnt_reg);
        stat.units_zero  = (units_reg == '0);
        stat.fill_ok     = have_col && (best_left != '0);
        stat.wcol_last   = (wcol_reg == IW'(MAX_N - 1));
        stat.emit_last   = ((CW'(er_reg) + CW'(1)) == pair_cnt_reg) && ec_wrap;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_cap_reg <= bmm_pkg::CAP_W'(1);
        end
        else if (cfg_we)
        begin
            entry_cap_reg <= cfg_wdata;
        end
    end

    // Run control state: counts, served rows, margin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_cnt_reg <= '0;
            row_cnt_reg  <= '0;
            served_reg   <= '0;
            margin_reg   <= '0;
        end
        else if (cmd.clear_run)
        begin
            pair_cnt_reg <= '0;
            row_cnt_reg  <= '0;
            served_reg   <= '0;
            margin_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                pair_cnt_reg <= pair_cnt_reg + CW'(1);
                margin_reg   <= margin_reg + bmm_pkg::MARGIN_W'(rt)
                                - bmm_pkg::MARGIN_W'(ct);
            end
            if (cmd.pick)
            begin
                row_cnt_reg          <= row_cnt_reg + CW'(1);
                served_reg[pick_row] <= 1'b1;
            end
        end
    end

    // Totals, per-row usage and the fill walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_need_reg[pair_cnt_reg[IW-1:0]] <= rt;
            col_left_reg[pair_cnt_reg[IW-1:0]] <= ct;
        end
        if (cmd.pick)
        begin
            cur_row_reg <= pick_row;
            units_reg   <= best_need;
            wcol_reg    <= '0;
            for (int i = 0; i < MAX_N; i++)
            begin
                row_use_reg[i] <= '0;
            end
        end
        if (cmd.fill)
        begin
            col_left_reg[pick_col] <= col_left_reg[pick_col] - TW'(1);
            row_use_reg[pick_col]  <= row_use_reg[pick_col] + bmm_pkg::CAP_W'(1);
            units_reg              <= units_reg - TW'(1);
        end
        if (cmd.write)
        begin
            wcol_reg <= wcol_reg + IW'(1);
        end
        if (cmd.emit_clear)
        begin
            er_reg <= '0;
            ec_reg <= '0;
        end
        else if (cmd.emit_next)
        begin
            if (ec_wrap)
            begin
                ec_reg <= '0;
                er_reg <= er_reg + IW'(1);
            end
            else
            begin
                ec_reg <= ec_reg + IW'(1);
            end
        end
    end

    // Entry store: one row written after it is filled, read back for output
    assign ram_we    = cmd.write;
    assign ram_waddr = {bmm_pkg::IDX_W'(cur_row_reg), bmm_pkg::IDX_W'(wcol_reg)};
    assign ram_raddr = {bmm_pkg::IDX_W'(er_reg), bmm_pkg::IDX_W'(ec_reg)};

    bmm_ram #(
        .WIDTH (bmm_pkg::CAP_W),
        .DEPTH (bmm_pkg::MAT_DEPTH)
    ) u_mat (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (row_use_reg[wcol_reg]),
        .re    (cmd.emit_read),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_ok)
        begin
            out_fld_reg  <= {ram_rdata, bmm_pkg::IDX_W'(ec_reg),
                             bmm_pkg::IDX_W'(er_reg), 1'b1};
            out_last_reg <= stat.emit_last;
        end
        else if (cmd.out_fail)
        begin
            out_fld_reg  <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign out_tdata = bmm_pkg::OUT_DATA_W'(out_fld_reg);
    assign out_tlast = out_last_reg;

    `BMM_ASSERT_IMP(a_fill_has_col, cmd.fill, stat.fill_ok, "fill without usable column")
    `BMM_ASSERT_IMP(a_pick_has_row, cmd.pick, have_row && !stat.rows_all, "pick with no row left")
    `BMM_ASSERT(a_pair_cnt_range, pair_cnt_reg <= CW'(MAX_N), "pair count overflow")

endmodule

>>> sv/bmm_ctrl.sv
// Controller: sequences loading, row fill, row write-back and result output.
module bmm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_tvalid,
    output logic               in_tready,
    output logic               out_tvalid,
    input  logic               out_tready,
    input  bmm_pkg::bmm_stat_t stat,
    output bmm_pkg::bmm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_PICK,
        S_FILL,
        S_WRITE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_OUT,
        S_FAIL,
        S_FAIL_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_acc;
    logic   out_acc;

    assign in_tready  = (state_reg == S_LOAD);
    assign out_tvalid = out_valid_reg;
    assign in_acc     = in_tvalid && in_tready;
    assign out_acc    = out_valid_reg && out_tready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    cmd.load = 1'b1;
                    if (stat.load_end)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.emit_clear = 1'b1;
                state_next     = stat.margin_zero ? S_PICK : S_FAIL;
            end
            S_PICK:
            begin
                if (stat.rows_all)
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (stat.units_zero)
                begin
                    state_next = S_WRITE;
                end
                else if (!stat.fill_ok)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    cmd.fill = 1'b1;
                end
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.wcol_last)
                begin
                    state_next = S_PICK;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.out_ok     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (stat.emit_last)
                    begin
                        cmd.clear_run = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            S_FAIL:
            begin
                cmd.out_fail   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_FAIL_OUT;
            end
            S_FAIL_OUT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    cmd.clear_run  = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next     = S_LOAD;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // State and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
